// ===== hw/rtl/tcw_pkg.sv =====
// Package for the text console character writer.
// Holds screen geometry, field widths, control codes, register indexes and
// the cell memory request type. Depends on nothing.
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_STOP  = 8;
   localparam int CELLS     = COLUMNS * ROWS;
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int PTR_W     = $clog2(CELLS + 1);

   // Field widths
   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int COLOUR_W  = 4;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = CHAR_W + ATTR_W;
   localparam int RES_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PUT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SET  = 2'd2;

   // Control characters
   localparam logic [CHAR_W-1:0] CTRL_CR  = 8'd13;
   localparam logic [CHAR_W-1:0] CTRL_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CTRL_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CTRL_BS  = 8'd8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_CHAR    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_ATTR    = 2'd2;

   // Reset values of the registers
   localparam logic [RES_W-1:0]  RESERVED_ROWS_RST = 5'd0;
   localparam logic [CHAR_W-1:0] BLANK_CHAR_RST    = 8'd32;
   localparam logic [ATTR_W-1:0] BLANK_ATTR_RST    = 8'd7;

   // Mark columns after which the next tab stop begins
   function automatic logic [COLUMNS-1:0] tab_edges();
      logic [COLUMNS-1:0] edges;
      edges = '0;
      for (int i = 0; i < COLUMNS; i++) begin
         if (((i + 1) % TAB_STOP) == 0) begin
            edges[i] = 1'b1;
         end
      end
      return edges;
   endfunction

   localparam logic [COLUMNS-1:0] TAB_EDGE = tab_edges();

   // Linear cell address of a screen position
   function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] y,
                                                   logic [COL_W-1:0] x);
      return ADDR_W'(int'(y) * COLUMNS + int'(x));
   endfunction

   // One cycle of cell memory traffic
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } tcw_mem_req_type;

endpackage

// ===== hw/rtl/tcw_req_if.sv =====
// Request channel of the text console character writer.
// Carries valid, ready and one request word. Depends on tcw_pkg.
interface tcw_req_if;
   logic                           valid;
   logic                           ready;
   logic [tcw_pkg::MODE_W-1:0]     mode;
   logic [tcw_pkg::CHAR_W-1:0]     char_code;
   logic [tcw_pkg::COLOUR_W-1:0]   fg_colour;
   logic [tcw_pkg::COLOUR_W-1:0]   bg_colour;
   logic [tcw_pkg::COL_W-1:0]      col;
   logic [tcw_pkg::ROW_W-1:0]      row;

   modport source (output valid, mode, char_code, fg_colour, bg_colour, col, row,
                   input ready);
   modport sink (input valid, mode, char_code, fg_colour, bg_colour, col, row,
                 output ready);
endinterface

// ===== hw/rtl/tcw_rsp_if.sv =====
// Response channel of the text console character writer.
// Carries valid, ready and one response word. Depends on tcw_pkg.
interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::COL_W-1:0]   cursor_col;
   logic [tcw_pkg::ROW_W-1:0]   cursor_row;
   logic [tcw_pkg::CHAR_W-1:0]  cell_char;
   logic [tcw_pkg::ATTR_W-1:0]  cell_attr;

   modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr,
                   input ready);
   modport sink (input valid, cursor_col, cursor_row, cell_char, cell_attr,
                 output ready);
endinterface

// ===== hw/rtl/tcw_cell_mem.sv =====
// Screen cell memory: one write port and one read port, registered read data.
// Depends on tcw_pkg for geometry and the request type.
module tcw_cell_mem (
   input  logic                         clock,
   input  tcw_pkg::tcw_mem_req_type     mem_req,
   output logic [tcw_pkg::CELL_W-1:0]   rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem_ff [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   // Write one cell
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Read one cell, data valid next cycle
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/text_console_char_writer_top.sv =====
// Top level of the text console character writer: handshakes, registers,
// cursor and the sequencer that walks the cell memory.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if and tcw_cell_mem.
//
//   channel  | role    | word
//   ---------+---------+------------------------------------------------------
//   req_chan | sink    | mode, char_code, fg_colour, bg_colour, col, row
//   rsp_chan | source  | cursor_col, cursor_row, cell_char, cell_attr
//   csr_*    | write   | csr_we, csr_index, csr_wdata (no read-back)
//
// A word is taken only when the sequencer is idle; ST_EXEC decodes it, then:
// a stored byte or a backspace passes through ST_WRITE and a cell read through ST_READ;
// CR, cursor set, the spare mode, an off-screen read and backspace at the origin go
// straight to ST_DONE; a line feed or tab fills cells (up to COLUMNS) in ST_WRITE,
// and a scroll copies (ROWS-1-reserved_rows)*COLUMNS cells in ST_COPY (none when
// reserved_rows >= ROWS-1) and blanks COLUMNS cells in ST_BLANK, one at a time through
// the single write port of the cell memory. ST_DONE moves the result into the output
// register, which may hold while the next word enters; while it is full the result
// waits and no new word is taken. After reset a clearing pass zeroes every cell of
// the memory; no word is taken during it, register writes are.
module text_console_char_writer_top (
   input  logic                             clock,
   input  logic                             reset,
   tcw_req_if.sink                          req_chan,
   tcw_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcw_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_WRITE,
      ST_READ,
      ST_COPY,
      ST_BLANK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      WK_CHAR,
      WK_BS,
      WK_LF,
      WK_TAB
   } write_kind_type;

   // Control state
   state_type                     state_ff, state_in;
   logic [tcw_pkg::PTR_W-1:0]     ptr_ff, ptr_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [tcw_pkg::COL_W-1:0]     cur_x_ff, cur_x_in;
   logic [tcw_pkg::ROW_W-1:0]     cur_y_ff, cur_y_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::RES_W-1:0]     res_rows_ff, res_rows_in;
   logic [tcw_pkg::CHAR_W-1:0]    blank_char_ff, blank_char_in;
   logic [tcw_pkg::ATTR_W-1:0]    blank_attr_ff, blank_attr_in;

   // Payload
   logic [tcw_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [tcw_pkg::CHAR_W-1:0]    char_ff, char_in;
   logic [tcw_pkg::ATTR_W-1:0]    attr_ff, attr_in;
   logic [tcw_pkg::COL_W-1:0]     col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [tcw_pkg::CELL_W-1:0]    wdata_ff, wdata_in;
   write_kind_type                wkind_ff, wkind_in;
   logic [tcw_pkg::CHAR_W-1:0]    cell_char_ff, cell_char_in;
   logic [tcw_pkg::ATTR_W-1:0]    cell_attr_ff, cell_attr_in;
   logic [tcw_pkg::COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [tcw_pkg::ATTR_W-1:0]    rsp_attr_ff, rsp_attr_in;

   tcw_pkg::tcw_mem_req_type      mem_req;
   logic [tcw_pkg::CELL_W-1:0]    rd_data;
   logic [tcw_pkg::PTR_W-1:0]     copy_dst;
   logic                          req_take;
   logic                          last_col;
   logic                          step_done;

   tcw_cell_mem u_cell_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && (state_ff == ST_IDLE);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_col = rsp_col_ff;
   assign rsp_chan.cursor_row = rsp_row_ff;
   assign rsp_chan.cell_char  = rsp_char_ff;
   assign rsp_chan.cell_attr  = rsp_attr_ff;

   // Destination of the copy read issued last cycle, one row above it
   assign copy_dst = ptr_ff - tcw_pkg::PTR_W'(tcw_pkg::COLUMNS + 1);
   assign last_col = (cur_x_ff == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      rd_vld_in     = rd_vld_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_rows_in   = res_rows_ff;
      blank_char_in = blank_char_ff;
      blank_attr_in = blank_attr_ff;
      mode_in       = mode_ff;
      char_in       = char_ff;
      attr_in       = attr_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      wdata_in      = wdata_ff;
      wkind_in      = wkind_ff;
      cell_char_in  = cell_char_ff;
      cell_attr_in  = cell_attr_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      mem_req       = '0;
      step_done     = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_we) begin
         case (csr_index)
            tcw_pkg::CSR_RESERVED_ROWS: res_rows_in   = csr_wdata[tcw_pkg::RES_W-1:0];
            tcw_pkg::CSR_BLANK_CHAR:    blank_char_in = csr_wdata[tcw_pkg::CHAR_W-1:0];
            tcw_pkg::CSR_BLANK_ATTR:    blank_attr_in = csr_wdata[tcw_pkg::ATTR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         // Zero every cell after reset
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ptr_ff[tcw_pkg::ADDR_W-1:0];
            mem_req.wdata = '0;
            if (ptr_ff == tcw_pkg::PTR_W'(tcw_pkg::CELLS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Capture the request word
         ST_IDLE: begin
            if (req_take) begin
               mode_in  = req_chan.mode;
               char_in  = req_chan.char_code;
               attr_in  = {req_chan.bg_colour, req_chan.fg_colour};
               col_in   = req_chan.col;
               row_in   = req_chan.row;
               state_in = ST_EXEC;
            end
         end

         // Decode the word
         ST_EXEC: begin
            cell_char_in = '0;
            cell_attr_in = '0;
            state_in     = ST_DONE;
            case (mode_ff)
               tcw_pkg::MODE_PUT: begin
                  case (char_ff)
                     tcw_pkg::CTRL_CR: begin
                        cur_x_in = '0;
                     end
                     tcw_pkg::CTRL_LF: begin
                        wdata_in = {attr_ff, blank_char_ff};
                        wkind_in = WK_LF;
                        state_in = ST_WRITE;
                     end
                     tcw_pkg::CTRL_TAB: begin
                        wdata_in = {attr_ff, blank_char_ff};
                        wkind_in = WK_TAB;
                        state_in = ST_WRITE;
                     end
                     tcw_pkg::CTRL_BS: begin
                        // Nothing to do at the origin
                        if ((cur_x_ff != '0) || (cur_y_ff != '0)) begin
                           if (cur_x_ff == '0) begin
                              cur_x_in = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
                              cur_y_in = cur_y_ff - 1'b1;
                           end else begin
                              cur_x_in = cur_x_ff - 1'b1;
                           end
                           wdata_in = {blank_attr_ff, blank_char_ff};
                           wkind_in = WK_BS;
                           state_in = ST_WRITE;
                        end
                     end
                     default: begin
                        wdata_in = {attr_ff, char_ff};
                        wkind_in = WK_CHAR;
                        state_in = ST_WRITE;
                     end
                  endcase
               end
               tcw_pkg::MODE_READ: begin
                  if ((col_ff < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                      (row_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS))) begin
                     mem_req.re    = 1'b1;
                     mem_req.raddr = tcw_pkg::cell_addr(row_ff, col_ff);
                     state_in      = ST_READ;
                  end
               end
               tcw_pkg::MODE_SET: begin
                  cur_x_in = (col_ff < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) ?
                             col_ff : tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
                  cur_y_in = (row_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) ?
                             row_ff : tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
               end
               default: ;
            endcase
         end

         // Write the cell under the cursor; but for a backspace, then advance, wrap and scroll
         ST_WRITE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = tcw_pkg::cell_addr(cur_y_ff, cur_x_ff);
            mem_req.wdata = wdata_ff;
            case (wkind_ff)
               WK_CHAR: step_done = 1'b1;
               WK_LF:   step_done = last_col;
               WK_TAB:  step_done = tcw_pkg::TAB_EDGE[cur_x_ff] || last_col;
               default: step_done = 1'b1;
            endcase
            if (wkind_ff == WK_BS) begin
               state_in = ST_DONE;
            end else if (!step_done) begin
               cur_x_in = cur_x_ff + 1'b1;
            end else if (!last_col) begin
               cur_x_in = cur_x_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               cur_x_in = '0;
               if (cur_y_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                  cur_y_in = cur_y_ff + 1'b1;
                  state_in = ST_DONE;
               end else if (res_rows_ff < tcw_pkg::RES_W'(tcw_pkg::ROWS - 1)) begin
                  // Scroll: start reading the row after the first row below the reserved area
                  ptr_in    = tcw_pkg::PTR_W'((int'(res_rows_ff) + 1) * tcw_pkg::COLUMNS);
                  rd_vld_in = 1'b0;
                  state_in  = ST_COPY;
               end else begin
                  ptr_in   = tcw_pkg::PTR_W'(tcw_pkg::LAST_BASE);
                  state_in = ST_BLANK;
               end
            end
         end

         // Move cells up one row: read ahead, write the previous read back
         ST_COPY: begin
            if (rd_vld_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = copy_dst[tcw_pkg::ADDR_W-1:0];
               mem_req.wdata = rd_data;
            end
            if (ptr_ff != tcw_pkg::PTR_W'(tcw_pkg::CELLS)) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = ptr_ff[tcw_pkg::ADDR_W-1:0];
               ptr_in        = ptr_ff + 1'b1;
               rd_vld_in     = 1'b1;
            end else begin
               rd_vld_in = 1'b0;
               ptr_in    = tcw_pkg::PTR_W'(tcw_pkg::LAST_BASE);
               state_in  = ST_BLANK;
            end
         end

         // Blank the last row
         ST_BLANK: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ptr_ff[tcw_pkg::ADDR_W-1:0];
            mem_req.wdata = {blank_attr_ff, blank_char_ff};
            if (ptr_ff == tcw_pkg::PTR_W'(tcw_pkg::CELLS - 1)) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Take the read cell
         ST_READ: begin
            cell_char_in = rd_data[tcw_pkg::CHAR_W-1:0];
            cell_attr_in = rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            state_in     = ST_DONE;
         end

         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = cur_x_ff;
               rsp_row_in   = cur_y_ff;
               rsp_char_in  = cell_char_ff;
               rsp_attr_in  = cell_attr_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ptr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         res_rows_ff   <= tcw_pkg::RESERVED_ROWS_RST;
         blank_char_ff <= tcw_pkg::BLANK_CHAR_RST;
         blank_attr_ff <= tcw_pkg::BLANK_ATTR_RST;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         rd_vld_ff     <= rd_vld_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_rows_ff   <= res_rows_in;
         blank_char_ff <= blank_char_in;
         blank_attr_ff <= blank_attr_in;
      end
   end

   // Hold the working word and the response word
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      char_ff      <= char_in;
      attr_ff      <= attr_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      wdata_ff     <= wdata_in;
      wkind_ff     <= wkind_in;
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
   end

   // Cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_x_ff < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
      (cur_y_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
      else $error("cursor outside the screen");

   // Cell writes only come from the walking states
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (state_ff == ST_CLEAR) || (state_ff == ST_WRITE) ||
                     (state_ff == ST_COPY) || (state_ff == ST_BLANK))
      else $error("cell write outside a write state");

   // An accepted word is decoded in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_EXEC))
      else $error("accepted word not decoded");

   // Read data is taken only after a read was issued
   a_read_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(mem_req.re))
      else $error("cell read taken without a read request");

endmodule
